@@ sv/irhf_pkg.sv @@
package irhf_pkg;

	localparam int SLOTS = 4;
	localparam int JOB_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SLOT_ENABLE = 3'd0;
	localparam logic [2:0] CFG_SLOT0 = 3'd1;

	// Verdict codes.
	localparam logic [3:0] V_UNICAST = 4'd0;
	localparam logic [3:0] V_LBCAST = 4'd1;
	localparam logic [3:0] V_DBCAST = 4'd2;
	localparam logic [3:0] V_SHORT_FRAME = 4'd3;
	localparam logic [3:0] V_BAD_VERSION = 4'd4;
	localparam logic [3:0] V_BAD_IHL = 4'd5;
	localparam logic [3:0] V_FRAME_LT_HDR = 4'd6;
	localparam logic [3:0] V_BAD_CSUM = 4'd7;
	localparam logic [3:0] V_TOT_LT_HDR = 4'd8;
	localparam logic [3:0] V_FRAME_LT_TOT = 4'd9;
	localparam logic [3:0] V_NO_SLOT = 4'd10;
	localparam logic [3:0] V_MCAST = 4'd11;
	localparam logic [3:0] V_NOT_LOCAL = 4'd12;

	localparam logic [3:0] IP_VERSION = 4'd4;
	localparam logic [3:0] MIN_IHL = 4'd5;
	localparam logic [15:0] MIN_FRAME = 16'd20;
	localparam logic [3:0] MCAST_PREFIX = 4'hE;
	localparam logic [31:0] LIMITED_BCAST = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] header_word;
		logic first;
		logic [15:0] frame_len;
	} item_t;

	typedef struct packed {
		logic [3:0] verdict;
		logic [7:0] protocol;
		logic [15:0] payload_len;
		logic [3:0] header_words;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [SLOTS-1:0] slot_mask;
	} result_t;

	// One finished header handed from the parser to the classifier.
	typedef struct packed {
		logic early;
		logic [3:0] early_verdict;
		logic [15:0] sum;
		logic [15:0] checksum;
		logic [15:0] total_len;
		logic [3:0] hlw;
		logic [15:0] frame_len;
		logic [7:0] protocol;
		logic [31:0] src;
		logic [31:0] dst;
	} job_t;

	typedef struct packed {
		logic [SLOTS-1:0] enable;
		logic [SLOTS-1:0][63:0] addr_mask;
	} slot_cfg_t;

endpackage

@@ sv/irhf_front.sv @@
module irhf_front import irhf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input item_t item,
	output logic job_push,
	output job_t job
);

	logic [3:0] idx_q;
	logic open_q;
	logic [15:0] sum_q;
	logic [15:0] csum_q;
	logic [15:0] total_q;
	logic [3:0] hlw_q;
	logic [15:0] flen_q;
	logic [7:0] proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;

	logic [31:0] word;
	logic [3:0] ihl;
	logic early_bad;
	logic [3:0] early_verdict;
	logic active;
	logic [3:0] idx;
	logic [15:0] sum_base;
	logic [15:0] sum_n;
	logic [15:0] csum_n;
	logic [15:0] total_n;
	logic [3:0] hlw_n;
	logic [15:0] flen_n;
	logic [7:0] proto_n;
	logic [31:0] src_n;
	logic [31:0] dst_n;
	logic last;

	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	always_comb begin
		word = item.header_word;
		ihl = word[27:24];
		early_bad = 1'b1;
		early_verdict = V_FRAME_LT_HDR;
		if (item.frame_len < MIN_FRAME) begin
			early_verdict = V_SHORT_FRAME;
		end else if (word[31:28] != IP_VERSION) begin
			early_verdict = V_BAD_VERSION;
		end else if (ihl < MIN_IHL) begin
			early_verdict = V_BAD_IHL;
		end else if (item.frame_len < {10'd0, ihl, 2'b00}) begin
			early_verdict = V_FRAME_LT_HDR;
		end else begin
			early_bad = 1'b0;
		end

		active = item.first ? !early_bad : open_q;
		idx = item.first ? 4'd0 : idx_q;
		sum_base = item.first ? 16'd0 : sum_q;
		hlw_n = item.first ? ihl : hlw_q;
		total_n = item.first ? word[15:0] : total_q;
		flen_n = item.first ? item.frame_len : flen_q;

		csum_n = csum_q;
		proto_n = proto_q;
		src_n = src_q;
		dst_n = dst_q;
		// The checksum halfword itself is left out of the sum.
		if (idx == 4'd2) begin
			sum_n = oc_add(sum_base, word[31:16]);
			csum_n = word[15:0];
			proto_n = word[23:16];
		end else begin
			sum_n = oc_add(oc_add(sum_base, word[31:16]), word[15:0]);
		end
		if (idx == 4'd3) begin
			src_n = word;
		end
		if (idx == 4'd4) begin
			dst_n = word;
		end
		last = ({1'b0, idx} + 5'd1) >= {1'b0, hlw_n};

		job.early = item.first && early_bad;
		job.early_verdict = early_verdict;
		job.sum = sum_n;
		job.checksum = csum_n;
		job.total_len = total_n;
		job.hlw = hlw_n;
		job.frame_len = flen_n;
		job.protocol = proto_n;
		job.src = src_n;
		job.dst = dst_n;
		job_push = accept && ((item.first && early_bad) || (active && last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			open_q <= 1'b0;
		end else if (accept) begin
			if (!active || last) begin
				open_q <= 1'b0;
			end else begin
				open_q <= 1'b1;
				idx_q <= idx + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && active) begin
			sum_q <= sum_n;
			csum_q <= csum_n;
			total_q <= total_n;
			hlw_q <= hlw_n;
			flen_q <= flen_n;
			proto_q <= proto_n;
			src_q <= src_n;
			dst_q <= dst_n;
		end
	end

endmodule

@@ sv/irhf_job_queue.sv @@
module irhf_job_queue import irhf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input job_t wr_job,
	output logic full,
	input logic rd_en,
	output logic rd_valid,
	output job_t rd_job
);

	localparam int PW = $clog2(JOB_DEPTH);

	job_t mem_q [JOB_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;

	assign full = count_q == (PW+1)'(JOB_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

@@ sv/irhf_back.sv @@
module irhf_back import irhf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input job_t job,
	output logic job_pop,
	input slot_cfg_t cfg,
	output logic empty,
	input logic pop,
	output result_t result
);

	localparam int OW = $clog2(OUT_DEPTH);

	result_t out_q [OUT_DEPTH];
	logic [OW-1:0] wr_ptr_q;
	logic [OW-1:0] rd_ptr_q;
	logic [OW:0] count_q;

	result_t res;
	logic [5:0] hdr_bytes;
	logic [15:0] plen;
	logic [SLOTS-1:0] ucast;
	logic [SLOTS-1:0] dbcast;
	logic out_full;
	logic do_pop;

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			ucast[s] = cfg.enable[s] && (cfg.addr_mask[s][63:32] != '0) &&
				(cfg.addr_mask[s][63:32] == job.dst);
			dbcast[s] = cfg.enable[s] && (cfg.addr_mask[s][31:0] != '0) &&
				((cfg.addr_mask[s][63:32] | ~cfg.addr_mask[s][31:0]) == job.dst);
		end
	end

	always_comb begin
		hdr_bytes = {job.hlw, 2'b00};
		plen = job.total_len - {10'd0, hdr_bytes};
		res.protocol = job.protocol;
		res.payload_len = '0;
		res.header_words = job.hlw;
		res.src_addr = job.src;
		res.dst_addr = job.dst;
		res.slot_mask = '0;
		if (job.early) begin
			res = '0;
			res.verdict = job.early_verdict;
		end else if (~job.sum != job.checksum) begin
			res.verdict = V_BAD_CSUM;
		end else if (job.total_len < {10'd0, hdr_bytes}) begin
			res.verdict = V_TOT_LT_HDR;
		end else if (job.frame_len < job.total_len) begin
			res.verdict = V_FRAME_LT_TOT;
		end else begin
			res.payload_len = plen;
			if (cfg.enable == '0) begin
				res.verdict = V_NO_SLOT;
			end else if (job.dst[31:28] == MCAST_PREFIX) begin
				res.verdict = V_MCAST;
			end else if (job.dst == LIMITED_BCAST) begin
				res.verdict = V_LBCAST;
				res.slot_mask = cfg.enable;
			end else if (ucast != '0) begin
				res.verdict = V_UNICAST;
				res.slot_mask = ucast;
			end else if (dbcast != '0) begin
				res.verdict = V_DBCAST;
				res.slot_mask = dbcast;
			end else begin
				res.verdict = V_NOT_LOCAL;
			end
		end
	end

	assign out_full = count_q == (OW+1)'(OUT_DEPTH);
	assign job_pop = job_valid && !out_full;
	assign empty = count_q == '0;
	assign do_pop = pop && !empty;
	assign result = out_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (job_pop) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (job_pop && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !job_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			out_q[wr_ptr_q] <= res;
		end
	end

endmodule

@@ sv/ipv4_receive_header_filter.sv @@
// Channel  Handshake              Payload
// input    push / full            item (header_word, first, frame_len)
// result   empty / pop            result (verdict ... slot_mask)
// config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One header word is taken every cycle while full is low; the header parser
// handles each word in the cycle it arrives.
// A verdict's job is queued when its deciding word is accepted; the verdict is
// registered in the result queue, ready to pop, once that queue has room.
// A four-entry job queue between parser and classifier and a two-entry
// result queue let either side stall without stopping the other.
// Reset clears all control state and the slot configuration.
module ipv4_receive_header_filter import irhf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input item_t item,
	output logic empty,
	input logic pop,
	output result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);

	slot_cfg_t cfg_q;
	logic accept;
	logic job_push;
	job_t job_in;
	logic job_valid;
	logic job_pop;
	job_t job_out;

	assign cfg_ready = 1'b1;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SLOT_ENABLE) begin
				cfg_q.enable <= cfg_data[SLOTS-1:0];
			end
			for (int s = 0; s < SLOTS; s++) begin
				if (cfg_index == CFG_SLOT0 + 3'(s)) begin
					cfg_q.addr_mask[s] <= cfg_data;
				end
			end
		end
	end

	irhf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.job_push(job_push),
		.job(job_in)
	);

	irhf_job_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(job_push),
		.wr_job(job_in),
		.full(full),
		.rd_en(job_pop),
		.rd_valid(job_valid),
		.rd_job(job_out)
	);

	irhf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job(job_out),
		.job_pop(job_pop),
		.cfg(cfg_q),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule
